// ===== hw/rtl/ssc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the swept sphere collision test.
package ssc_pkg;

	// Default number of fraction bits of the fixed-point operands.
	localparam int FRAC_BITS_DEF = 16;

	// Width of the window register and its value after reset.
	localparam int         DT_W     = 31;
	localparam logic [30:0] DT_RESET = 31'd1092;

	// Width of the exact coefficients a, |h| and |c|.
	localparam int COEF_W = 64;

	// Outcome codes.
	localparam logic [2:0] OC_HIT       = 3'd0;
	localparam logic [2:0] OC_DISC_NEG  = 3'd1;
	localparam logic [2:0] OC_NO_MOTION = 3'd2;
	localparam logic [2:0] OC_BEFORE    = 3'd3;
	localparam logic [2:0] OC_AFTER     = 3'd4;

	// One sphere pair.
	typedef struct packed {
		logic signed [31:0] rel_pos_x;
		logic signed [31:0] rel_pos_y;
		logic signed [31:0] rel_pos_z;
		logic signed [31:0] rel_vel_x;
		logic signed [31:0] rel_vel_y;
		logic signed [31:0] rel_vel_z;
		logic        [30:0] radius_sum;
	} pair_t;

	// One test result.
	typedef struct packed {
		logic       hit;
		logic [2:0] outcome;
	} result_t;

	// Load enables of the three stages of the wide multiplier.
	typedef struct packed {
		logic pp;
		logic row;
		logic sum;
	} mul_en_t;

endpackage

// ===== hw/rtl/ssc_wmul.sv =====
`timescale 1ns / 1ps
// Three-stage pipelined unsigned wide multiplier built from 32x32 partial products.
module ssc_wmul #(
	parameter int AW = 64,
	parameter int BW = 64
) (
	input  logic                 clk,
	input  ssc_pkg::mul_en_t     en,
	input  logic [AW-1:0]        a,
	input  logic [BW-1:0]        b,
	output logic [AW+BW-1:0]     p
);
	import ssc_pkg::*;

	localparam int NA  = (AW + 31) / 32;
	localparam int NB  = (BW + 31) / 32;
	localparam int AXW = NA * 32;
	localparam int BXW = NB * 32;
	localparam int RW  = BXW + 32;
	localparam int PW  = AXW + BXW;

	logic [AXW-1:0]  a_ext;
	logic [BXW-1:0]  b_ext;
	logic [63:0]     pp_s1 [NA][NB];
	logic [RW-1:0]   row_c [NA];
	logic [RW-1:0]   row_s2 [NA];
	logic [PW-1:0]   sum_c;
	logic [AW+BW-1:0] p_s3;

	assign a_ext = AXW'(a);
	assign b_ext = BXW'(b);

	// Stage one: every limb pair multiplied on its own.
	always_ff @(posedge clk) begin
		if (en.pp) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s1[i][j] <= 64'(a_ext[32*i +: 32]) * 64'(b_ext[32*j +: 32]);
				end
			end
		end
	end

	// Stage two: the partial products of one limb of a summed into a row.
	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < NB; j++) begin
				row_c[i] = row_c[i] + (RW'(pp_s1[i][j]) << (32 * j));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.row) begin
			row_s2 <= row_c;
		end
	end

	// Stage three: the rows summed into the full product.
	always_comb begin
		sum_c = '0;
		for (int i = 0; i < NA; i++) begin
			sum_c = sum_c + (PW'(row_s2[i]) << (32 * i));
		end
	end

	always_ff @(posedge clk) begin
		if (en.sum) begin
			p_s3 <= sum_c[AW+BW-1:0];
		end
	end

	assign p = p_s3;

endmodule

// ===== hw/rtl/swept_sphere_collision_test_top.sv =====
`timescale 1ns / 1ps
// Top level of the swept sphere time-of-impact test pipeline.
//
// Each transfer on the pair channel carries one sphere pair (relative position,
// relative velocity and summed radii, all fixed point with FRAC_BITS fraction
// bits), and for each pair exactly one result leaves on the res channel, in
// order. The block takes one pair per clock cycle while pair_stall is low, and
// a result leaves once its pair has passed through the eleven register stages
// of the pipeline: input products, coefficient sums, magnitudes, three stages
// of wide multiplication for h*h, a*c and a*dt, the discriminant and window
// compare, three stages of wide multiplication for the final squared
// distance, and the output register. Stages advance on their own, so bubbles
// close up and a stalled output does not block pairs until the pipeline is full.
// All arithmetic is exact: the discriminant is tested as h*h against a*c with
// h = dv.dp, and the root is placed against 0 and dt_window without any square
// root or division. The window register is written through the cfg channel,
// which is always ready; it is 1092 after reset and is to be written only while
// no pair is in flight.
module swept_sphere_collision_test_top #(
	parameter int FRAC_BITS = ssc_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pair_valid,
	output logic                          pair_stall,
	input  ssc_pkg::pair_t                pair,
	output logic                          res_valid,
	input  logic                          res_stall,
	output ssc_pkg::result_t              res,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ssc_pkg::DT_W-1:0]      cfg_data
);
	import ssc_pkg::*;

	localparam int NSTG = 11;
	localparam int LW   = COEF_W + FRAC_BITS;
	localparam int YW   = COEF_W + DT_W;
	localparam int XW   = (LW > YW) ? LW : YW;
	localparam int CW2  = 2 * COEF_W;

	// Side information that rides along with the first wide multiplication.
	typedef struct packed {
		logic [COEF_W-1:0] hmag;
		logic              cneg;
		logic              azero;
		logic              hpos;
	} side_t;

	// Side information that rides along with the second wide multiplication.
	typedef struct packed {
		logic [2:0]     outcome;
		logic           need_ll;
		logic [CW2-1:0] d;
	} tail_t;

	logic [DT_W-1:0]  dt_q;
	logic [NSTG:1]    vld_q;
	logic [NSTG:1]    adv;

	// Stage 1 products.
	logic signed [63:0] vv_s1 [3];
	logic signed [63:0] psq_s1 [3];
	logic signed [63:0] vp_s1 [3];
	logic [61:0]        rr_s1;

	// Stage 2 sums.
	logic [COEF_W-1:0]  a_s2;
	logic [COEF_W-1:0]  psq_s2;
	logic signed [64:0] h_s2;
	logic [61:0]        rr_s2;

	// Stage 3 magnitudes.
	logic [COEF_W-1:0] a_s3;
	logic [COEF_W-1:0] cmag_s3;
	side_t             side_s3;
	side_t             side_s4;
	side_t             side_s5;
	side_t             side_s6;

	logic [CW2-1:0]   hh;
	logic [CW2-1:0]   ac;
	logic [YW-1:0]    y;

	logic [XW-1:0]    x_c;
	logic [XW-1:0]    y_c;
	logic [XW-1:0]    l_c;
	tail_t            tail_c;

	logic [LW-1:0]    l_s7;
	tail_t            tail_s7;
	tail_t            tail_s8;
	tail_t            tail_s9;
	tail_t            tail_s10;

	logic [2*LW-1:0]  ll;
	logic [2*LW-1:0]  dsh_c;
	logic [2:0]       fin_c;
	result_t          res_s11;

	// The window register; the channel never holds off a write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= DT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dt_q <= cfg_data;
		end
	end

	// A stage loads when it is empty or when the stage after it loads.
	always_comb begin
		adv[NSTG] = !vld_q[NSTG] || !res_stall;
		for (int k = NSTG - 1; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign pair_stall = !adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= pair_valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: the ten 32x32 products of the coefficients.
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			vv_s1[0]  <= pair.rel_vel_x * pair.rel_vel_x;
			vv_s1[1]  <= pair.rel_vel_y * pair.rel_vel_y;
			vv_s1[2]  <= pair.rel_vel_z * pair.rel_vel_z;
			psq_s1[0] <= pair.rel_pos_x * pair.rel_pos_x;
			psq_s1[1] <= pair.rel_pos_y * pair.rel_pos_y;
			psq_s1[2] <= pair.rel_pos_z * pair.rel_pos_z;
			vp_s1[0]  <= pair.rel_vel_x * pair.rel_pos_x;
			vp_s1[1]  <= pair.rel_vel_y * pair.rel_pos_y;
			vp_s1[2]  <= pair.rel_vel_z * pair.rel_pos_z;
			rr_s1     <= 62'(pair.radius_sum) * 62'(pair.radius_sum);
		end
	end

	// Stage 2: a = |dv|^2, |dp|^2 and the signed half coefficient h = dv.dp.
	// Squares are never negative, so their bits are taken as unsigned.
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			a_s2   <= 64'(unsigned'(vv_s1[0])) + 64'(unsigned'(vv_s1[1]))
				+ 64'(unsigned'(vv_s1[2]));
			psq_s2 <= 64'(unsigned'(psq_s1[0])) + 64'(unsigned'(psq_s1[1]))
				+ 64'(unsigned'(psq_s1[2]));
			h_s2   <= $signed({vp_s1[0][63], vp_s1[0]}) + $signed({vp_s1[1][63], vp_s1[1]})
				+ $signed({vp_s1[2][63], vp_s1[2]});
			rr_s2  <= rr_s1;
		end
	end

	// Stage 3: magnitudes and signs of h and c = |dp|^2 - r^2.
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			a_s3          <= a_s2;
			side_s3.hmag  <= h_s2[64] ? 64'(-h_s2) : h_s2[63:0];
			side_s3.hpos  <= !h_s2[64] && (h_s2 != '0);
			side_s3.azero <= (a_s2 == '0);
			side_s3.cneg  <= (psq_s2 < 64'(rr_s2));
			cmag_s3       <= (psq_s2 < 64'(rr_s2)) ? (64'(rr_s2) - psq_s2)
				: (psq_s2 - 64'(rr_s2));
		end
	end

	// Stages 4 to 6: h*h, a*c and a*dt.
	ssc_wmul #(.AW(COEF_W), .BW(COEF_W)) u_mul_hh (
		.clk (clk),
		.en  ('{pp: adv[4], row: adv[5], sum: adv[6]}),
		.a   (side_s3.hmag),
		.b   (side_s3.hmag),
		.p   (hh)
	);

	ssc_wmul #(.AW(COEF_W), .BW(COEF_W)) u_mul_ac (
		.clk (clk),
		.en  ('{pp: adv[4], row: adv[5], sum: adv[6]}),
		.a   (a_s3),
		.b   (cmag_s3),
		.p   (ac)
	);

	ssc_wmul #(.AW(COEF_W), .BW(DT_W)) u_mul_adt (
		.clk (clk),
		.en  ('{pp: adv[4], row: adv[5], sum: adv[6]}),
		.a   (a_s3),
		.b   (dt_q),
		.p   (y)
	);

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			side_s4 <= side_s3;
		end
		if (adv[5]) begin
			side_s5 <= side_s4;
		end
		if (adv[6]) begin
			side_s6 <= side_s5;
		end
	end

	// Stage 7: the discriminant sign and the early outcomes. With h <= 0 and
	// c >= 0 the earlier root is t = (|h| - sqrt(h^2 - ac)) / a; it is inside the
	// window at once when |h| <= a*dt, otherwise it is inside exactly when
	// (|h| - a*dt)^2 <= h^2 - ac, all scaled by the fraction bits.
	always_comb begin
		x_c = XW'({side_s6.hmag, {FRAC_BITS{1'b0}}});
		y_c = XW'(y);
		l_c = x_c - y_c;
		tail_c.d       = hh - ac;
		tail_c.need_ll = 1'b0;
		if (!side_s6.cneg && (hh < ac)) begin
			tail_c.outcome = OC_DISC_NEG;
		end else if (side_s6.azero) begin
			tail_c.outcome = OC_NO_MOTION;
		end else if (side_s6.cneg || side_s6.hpos) begin
			tail_c.outcome = OC_BEFORE;
		end else if (x_c <= y_c) begin
			tail_c.outcome = OC_HIT;
		end else begin
			tail_c.outcome = OC_AFTER;
			tail_c.need_ll = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			l_s7    <= l_c[LW-1:0];
			tail_s7 <= tail_c;
		end
	end

	// Stages 8 to 10: the squared distance from the window end.
	ssc_wmul #(.AW(LW), .BW(LW)) u_mul_ll (
		.clk (clk),
		.en  ('{pp: adv[8], row: adv[9], sum: adv[10]}),
		.a   (l_s7),
		.b   (l_s7),
		.p   (ll)
	);

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			tail_s8 <= tail_s7;
		end
		if (adv[9]) begin
			tail_s9 <= tail_s8;
		end
		if (adv[10]) begin
			tail_s10 <= tail_s9;
		end
	end

	// Stage 11: final decision into the output register.
	always_comb begin
		dsh_c = {tail_s10.d, {(2 * FRAC_BITS){1'b0}}};
		if (tail_s10.need_ll) begin
			fin_c = (ll <= dsh_c) ? OC_HIT : OC_AFTER;
		end else begin
			fin_c = tail_s10.outcome;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[11]) begin
			res_s11.outcome <= fin_c;
			res_s11.hit     <= (fin_c == OC_HIT);
		end
	end

	assign res_valid = vld_q[NSTG];
	assign res       = res_s11;

endmodule

// ===== bench/swept_sphere_collision_test_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the swept sphere time-of-impact test pipeline.
module swept_sphere_collision_test_top_tb;
	import ssc_pkg::*;

	// Fixed-point scale of the instance under test, one unit and one second.
	localparam int               FRAC = FRAC_BITS_DEF;
	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC;

	// Pipeline depth from the top-level description, used for the final drain.
	localparam int LATENCY = 11;
	// Generous bound on the whole run; the slowest legal run is far below it.
	localparam int CYCLE_LIMIT = 400000;
	// Length of the long receiver hold that backs the pipeline up.
	localparam int PRESSURE_CYCLES = 400;

	// Holds the expected outcomes of accepted pairs, in order, and checks
	// each result transfer against the oldest one.
	class impact_scoreboard;
		logic [DT_W-1:0] window = DT_RESET;
		result_t         expected_outcomes[$];
		int              mismatches = 0;
		int              results_seen = 0;

		task report_mismatch(string msg);
			$display("mismatch at result %0d: %s", results_seen, msg);
			mismatches++;
		endtask

		// Exact time-of-impact classification. The coefficients a, h = dv.dp and
		// c = |dp|^2 - r^2 fit in 66 signed bits; every product after that is
		// taken on 256-bit unsigned magnitudes, so nothing ever wraps.
		function result_t predict_outcome(pair_t p);
			logic signed [65:0] px, py, pz, vx, vy, vz, rr, h, a, c;
			logic [65:0]        hm, cm;
			logic [255:0]       wh, wa, wc, hh, ac, x, y, l;
			logic [2:0]         oc;
			result_t            r;
			px = p.rel_pos_x;
			py = p.rel_pos_y;
			pz = p.rel_pos_z;
			vx = p.rel_vel_x;
			vy = p.rel_vel_y;
			vz = p.rel_vel_z;
			rr = {35'd0, p.radius_sum};
			a = vx * vx + vy * vy + vz * vz;
			h = vx * px + vy * py + vz * pz;
			c = px * px + py * py + pz * pz - rr * rr;
			hm = (h < 0) ? -h : h;
			cm = (c < 0) ? -c : c;
			wh = {190'd0, hm};
			wa = {190'd0, a};
			wc = {190'd0, cm};
			hh = wh * wh;
			ac = wa * wc;
			// The discriminant test comes first; it only applies when c is not
			// negative, since with c < 0 the product -a*c makes it positive.
			if (c >= 0 && hh < ac) begin
				oc = OC_DISC_NEG;
			end else if (a == 0) begin
				oc = OC_NO_MOTION;
			end else if (c < 0 || h > 0) begin
				oc = OC_BEFORE;
			end else begin
				// t = (|h| - sqrt(h^2 - a*c)) / a against dt, all scaled by 2^F.
				x = wh << FRAC;
				y = wa * {225'd0, window};
				if (x <= y) begin
					oc = OC_HIT;
				end else begin
					l = x - y;
					oc = (l * l <= ((hh - ac) << (2 * FRAC))) ? OC_HIT : OC_AFTER;
				end
			end
			r.hit = (oc == OC_HIT);
			r.outcome = oc;
			return r;
		endfunction

		function void note_pair(pair_t p);
			expected_outcomes.push_back(predict_outcome(p));
		endfunction

		task check_result(result_t got);
			result_t want;
			if (expected_outcomes.size() == 0) begin
				report_mismatch($sformatf("unexpected result hit=%0b outcome=%0d",
					got.hit, got.outcome));
			end else begin
				want = expected_outcomes.pop_front();
				if (got.hit !== want.hit)
					report_mismatch($sformatf("hit %0b, expected %0b", got.hit, want.hit));
				if (got.outcome !== want.outcome)
					report_mismatch($sformatf("outcome %0d, expected %0d",
						got.outcome, want.outcome));
			end
			results_seen++;
		endtask

		function int pending();
			return expected_outcomes.size();
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	logic            pair_valid;
	logic            pair_stall;
	pair_t           pair;
	logic            res_valid;
	logic            res_stall;
	result_t         res;
	logic            cfg_valid;
	logic            cfg_ready;
	logic [DT_W-1:0] cfg_data;

	impact_scoreboard sb = new();

	// Idling controls, set by the main sequence per phase and read by the
	// sender task and the receiver process.
	int send_idle_pct = 0;
	int stall_pct = 0;
	bit hold_request = 1'b0;
	int cycle_count = 0;

	swept_sphere_collision_test_top #(
		.FRAC_BITS(FRAC)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pair_valid(pair_valid),
		.pair_stall(pair_stall),
		.pair      (pair),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// A run that stops making progress ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Receiver side. Values are sampled at the rising edge before any update of
	// that edge lands, so a transfer is seen exactly when valid was high and
	// stall was low. The long hold is counted here, independent of the sender,
	// so the pipeline fills and pushes back on the pair channel.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (res_valid === 1'b1 && res_stall == 1'b0)
				sb.check_result(res);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = PRESSURE_CYCLES;
			end
			if (hold_left > 0) begin
				res_stall <= 1'b1;
				hold_left--;
			end else begin
				res_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	function automatic pair_t make_pair(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] pz, logic signed [31:0] vx, logic signed [31:0] vy,
			logic signed [31:0] vz, logic [31:0] r);
		pair_t p;
		p.rel_pos_x = px;
		p.rel_pos_y = py;
		p.rel_pos_z = pz;
		p.rel_vel_x = vx;
		p.rel_vel_y = vy;
		p.rel_vel_z = vz;
		p.radius_sum = r[30:0];
		return p;
	endfunction

	// Most pairs are built around a chosen contact time: the position is the
	// velocity run back over a time drawn from twice the window, plus a miss
	// offset on the scale of the radius. The rest are raw bit patterns, pairs
	// with no relative motion, small values, and pairs moving apart.
	function automatic pair_t random_pair(logic [DT_W-1:0] window);
		pair_t             p;
		int                sel, vsh, nsh, i;
		longint            t, pos;
		logic signed [31:0] vel[3];
		logic signed [31:0] loc[3];
		sel = $urandom_range(99);
		vsh = $urandom_range(1, 31);
		nsh = $urandom_range(6, 30);
		t = longint'($urandom) % (2 * longint'(window) + 2);
		p.radius_sum = 31'($urandom >> nsh);
		for (i = 0; i < 3; i++) begin
			vel[i] = $signed($urandom) >>> vsh;
			pos = (longint'(vel[i]) * t) >>> FRAC;
			if (sel >= 30)
				pos = -pos;
			pos = pos + longint'($signed($urandom) >>> nsh);
			if (pos > 64'sd2147483647)
				pos = 64'sd2147483647;
			if (pos < -64'sd2147483648)
				pos = -64'sd2147483648;
			loc[i] = pos[31:0];
		end
		if (sel < 10) begin
			for (i = 0; i < 3; i++) begin
				loc[i] = $urandom;
				vel[i] = $urandom;
			end
			p.radius_sum = 31'($urandom);
		end else if (sel < 18) begin
			for (i = 0; i < 3; i++)
				vel[i] = '0;
		end else if (sel < 26) begin
			for (i = 0; i < 3; i++) begin
				loc[i] = $signed($urandom) >>> 18;
				vel[i] = $signed($urandom) >>> 18;
			end
			p.radius_sum = 31'($urandom >> 18);
		end
		p.rel_pos_x = loc[0];
		p.rel_pos_y = loc[1];
		p.rel_pos_z = loc[2];
		p.rel_vel_x = vel[0];
		p.rel_vel_y = vel[1];
		p.rel_vel_z = vel[2];
		return p;
	endfunction

	// Offers one pair, after a random gap, and holds it until the transfer.
	task automatic send_pair(pair_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			pair_valid <= 1'b0;
			@(posedge clk);
		end
		pair_valid <= 1'b1;
		pair <= p;
		do
			@(posedge clk);
		while (pair_stall !== 1'b0);
		sb.note_pair(p);
	endtask

	// Every pair yields a result, so once none is outstanding the block is
	// idle and the window can change.
	task automatic write_window(logic [DT_W-1:0] value);
		while (sb.pending() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		sb.window = value;
	endtask

	// Contact exactly at zero, exactly at the window end, and just past it; the last
	// two only for a window below 31'h3FFF0000. One unit of closing speed per second.
	task automatic send_window_edges();
		logic signed [31:0] w;
		w = {1'b0, sb.window};
		send_pair(make_pair(ONE, 0, 0, -ONE, 0, 0, ONE));
		if (sb.window < 31'h3FFF0000) begin
			send_pair(make_pair(ONE + w, 0, 0, -ONE, 0, 0, ONE));
			send_pair(make_pair(ONE + w + 1, 0, 0, -ONE, 0, 0, ONE));
		end
	endtask

	task automatic run_phase(int count);
		int k;
		send_window_edges();
		for (k = 0; k < count; k++)
			send_pair(random_pair(sb.window));
		pair_valid <= 1'b0;
	endtask

	initial begin : main
		arst_n = 1'b0;
		pair_valid = 1'b0;
		pair = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pairs under the reset window: field extremes first, then one
		// pair per geometric case.
		send_pair(make_pair(0, 0, 0, 0, 0, 0, 0));
		send_pair(make_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
		send_pair(make_pair(32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 0));
		send_pair(make_pair(32'h80000000, 32'h80000000, 32'h80000000,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
		send_pair(make_pair(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0));
		// Coincident centers with no motion, the largest radius.
		send_pair(make_pair(0, 0, 0, 0, 0, 0, 32'h7FFFFFFF));
		// Separated with no motion.
		send_pair(make_pair(3 * ONE, 0, 0, 0, 0, 0, ONE));
		// Root at zero, at the window end, and just after it.
		send_window_edges();
		// Passing wide of each other: negative discriminant.
		send_pair(make_pair(4 * ONE, 2 * ONE, 0, -ONE, 0, 0, ONE));
		// Grazing contact with a zero discriminant, early in the window.
		send_pair(make_pair(500, ONE, 0, -ONE, 0, 0, ONE));
		// Already overlapping, approaching and receding.
		send_pair(make_pair(ONE / 2, 0, 0, -ONE, 0, 0, ONE));
		send_pair(make_pair(ONE / 2, 0, 0, ONE, 0, 0, ONE));
		// Apart and moving apart.
		send_pair(make_pair(4 * ONE, 0, 0, ONE, 0, 0, ONE));
		// Touching while sliding sideways: h and c both zero.
		send_pair(make_pair(ONE, 0, 0, 0, ONE, 0, ONE));
		// Apart and sliding sideways: h zero, c positive.
		send_pair(make_pair(2 * ONE, 0, 0, 0, ONE, 0, ONE));
		// Fast diagonal approach along y and z.
		send_pair(make_pair(0, -8 * ONE, 8 * ONE, 0, 400 * ONE, -400 * ONE, ONE));

		// Random phases, each with its own window and idling pattern. The
		// window goes through zero, its maximum, one second and random values.
		run_phase(250);

		write_window(31'h7FFFFFFF);
		send_idle_pct = 78;
		run_phase(250);

		write_window(31'd0);
		send_idle_pct = 0;
		stall_pct = 78;
		run_phase(250);

		write_window(ONE[DT_W-1:0]);
		send_idle_pct = 14;
		stall_pct = 14;
		run_phase(250);

		// The receiver holds off for a long stretch while pairs keep coming.
		write_window(DT_W'($urandom));
		send_idle_pct = 0;
		stall_pct = 0;
		hold_request = 1'b1;
		run_phase(250);

		write_window(DT_W'($urandom_range(1, 5000)));
		send_idle_pct = 14;
		stall_pct = 14;
		run_phase(200);

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		if (sb.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== swept_sphere_collision_test_top.f =====
hw/rtl/ssc_pkg.sv
hw/rtl/ssc_wmul.sv
hw/rtl/swept_sphere_collision_test_top.sv
bench/swept_sphere_collision_test_top_tb.sv
